[rtl/aai_pkg.sv]
// Shared types and constants for the actuator arm interlock.
`default_nettype none

package aai_pkg;

  // Position wrap period is 2^WRAP_BITS units (4 to 30).
  localparam int WRAP_BITS = 16;
  localparam int DELTA_W   = WRAP_BITS + 2;
  localparam int SUM_W     = 34;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam delta_t PERIOD = delta_t'(1) <<< WRAP_BITS;
  localparam delta_t HALF_P = delta_t'(1) <<< (WRAP_BITS - 1);
  localparam delta_t HALF_N = -HALF_P;

  localparam logic [23:0] AGE_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_READY = 2'd1,
    MODE_ARMED = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_STATUS = 3'd1,
    OP_STATE  = 3'd2,
    OP_OPER   = 3'd3,
    OP_TARGET = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SC_DISARM = 2'd0,
    SC_ARM    = 2'd1,
    SC_CLEAR  = 2'd2,
    SC_NONE   = 2'd3
  } state_cmd_t;

  typedef enum logic [2:0] {
    CFG_TIMEOUT     = 3'd0,
    CFG_ALLOW_NOPWR = 3'd1,
    CFG_VERSION     = 3'd2,
    CFG_SERVO_FAULT = 3'd3,
    CFG_READY_MASK  = 3'd4,
    CFG_MOVE_CODE   = 3'd5,
    CFG_REF_CODE    = 3'd6,
    CFG_CLEAR_CODE  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        status_version;
    logic [15:0]        status_error_flags;
    logic [15:0]        status_info_flags;
    logic signed [31:0] status_position;
    logic [1:0]         mode_cmd;
    logic [7:0]         detwist_command;
    logic signed [31:0] command_position;
  } in_beat_t;

  typedef struct packed {
    logic               send_command;
    logic [7:0]         command_code;
    logic signed [31:0] position;
    logic [15:0]        command_sequence;
    logic [1:0]         actuator_state;
    logic               status_accepted;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/actuator_arm_interlock_core.sv]
// Actuator arm interlock: mode tracking, status aging and command gating.
// A beat accepted into the input register moves on to the result register when it is not stalled.
// Throughput: one beat per cycle while out_stall is low; input and result registers run as a pipe.
// The mode, status age, last position and sequence update in the result stage.
// Reset (rst_n low, synchronous): mode init, status age stale (all ones),
// last position and sequence zero, configuration registers at their defaults.
`default_nettype none

module actuator_arm_interlock_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [23:0]        cfg_wdata,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_operation,
  input  wire  [15:0]        in_status_version,
  input  wire  [15:0]        in_status_error_flags,
  input  wire  [15:0]        in_status_info_flags,
  input  wire  signed [31:0] in_status_position,
  input  wire  [1:0]         in_mode_cmd,
  input  wire  [7:0]         in_detwist_command,
  input  wire  signed [31:0] in_command_position,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_send_command,
  output logic [7:0]         out_command_code,
  output logic signed [31:0] out_position,
  output logic [15:0]        out_command_sequence,
  output logic [1:0]         out_actuator_state,
  output logic               out_status_accepted
);

  // Configuration registers
  logic [23:0] timeout_r;
  logic        allow_r;
  logic [15:0] version_r;
  logic [15:0] servo_fault_r;
  logic [15:0] ready_mask_r;
  logic [7:0]  move_code_r;
  logic [7:0]  ref_code_r;
  logic [7:0]  clear_code_r;

  // Interlock state
  aai_pkg::mode_t     mode_r, mode_nxt;
  logic [23:0]        age_r, age_nxt;
  logic signed [31:0] last_pos_r, last_pos_nxt;
  logic [15:0]        seq_r, seq_nxt;

  // Pipe registers
  logic               s1_valid_r;
  aai_pkg::in_beat_t  s1_r;
  logic               out_valid_r;
  aai_pkg::out_beat_t out_r, res;

  logic advance;
  logic emit;
  logic [7:0]         emit_code;
  logic signed [31:0] emit_pos;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= 24'd1000;
      allow_r       <= 1'b0;
      version_r     <= 16'd0;
      servo_fault_r <= 16'd1;
      ready_mask_r  <= 16'd1;
      move_code_r   <= 8'd1;
      ref_code_r    <= 8'd2;
      clear_code_r  <= 8'd112;
    end else if (cfg_we) begin
      case (aai_pkg::cfg_idx_t'(cfg_index))
        aai_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_wdata;
        aai_pkg::CFG_ALLOW_NOPWR: allow_r       <= cfg_wdata[0];
        aai_pkg::CFG_VERSION:     version_r     <= cfg_wdata[15:0];
        aai_pkg::CFG_SERVO_FAULT: servo_fault_r <= cfg_wdata[15:0];
        aai_pkg::CFG_READY_MASK:  ready_mask_r  <= cfg_wdata[15:0];
        aai_pkg::CFG_MOVE_CODE:   move_code_r   <= cfg_wdata[7:0];
        aai_pkg::CFG_REF_CODE:    ref_code_r    <= cfg_wdata[7:0];
        aai_pkg::CFG_CLEAR_CODE:  clear_code_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r.operation          <= in_operation;
      s1_r.status_version     <= in_status_version;
      s1_r.status_error_flags <= in_status_error_flags;
      s1_r.status_info_flags  <= in_status_info_flags;
      s1_r.status_position    <= in_status_position;
      s1_r.mode_cmd           <= in_mode_cmd;
      s1_r.detwist_command    <= in_detwist_command;
      s1_r.command_position   <= in_command_position;
    end
  end

  // Per-beat state update and command formation
  always_comb begin
    logic [7:0]      code_raw;
    logic            fresh;
    logic            err_hit;
    aai_pkg::delta_t delta;
    aai_pkg::sum_t   sum;

    mode_nxt     = mode_r;
    age_nxt      = age_r;
    last_pos_nxt = last_pos_r;
    seq_nxt      = seq_r;
    emit         = 1'b0;
    code_raw     = 8'd0;
    emit_pos     = 32'sd0;
    res          = '0;
    fresh        = 1'b0;
    err_hit      = 1'b0;
    delta        = '0;
    sum          = '0;

    case (aai_pkg::op_t'(s1_r.operation))
      aai_pkg::OP_TICK: begin
        if (age_r != aai_pkg::AGE_MAX) begin
          age_nxt = age_r + 24'd1;
        end
        if (!(age_nxt < timeout_r) &&
            (mode_r inside {aai_pkg::MODE_READY, aai_pkg::MODE_ARMED})) begin
          mode_nxt = aai_pkg::MODE_INIT;
        end
      end
      aai_pkg::OP_STATUS: begin
        if (s1_r.status_version == version_r) begin
          res.status_accepted = 1'b1;
          last_pos_nxt = s1_r.status_position;
          age_nxt      = 24'd0;
          if (timeout_r == 24'd0) begin
            if (mode_r inside {aai_pkg::MODE_READY, aai_pkg::MODE_ARMED}) begin
              mode_nxt = aai_pkg::MODE_INIT;
            end
          end else begin
            err_hit = (s1_r.status_error_flags != 16'd0) &&
                      !(allow_r && s1_r.status_error_flags == servo_fault_r);
            if (err_hit) begin
              mode_nxt = aai_pkg::MODE_ERROR;
            end
            if ((s1_r.status_info_flags & ready_mask_r) != 16'd0 || allow_r) begin
              if (mode_nxt == aai_pkg::MODE_INIT) begin
                mode_nxt = aai_pkg::MODE_READY;
              end
            end else if (mode_nxt inside {aai_pkg::MODE_READY, aai_pkg::MODE_ARMED}) begin
              mode_nxt = aai_pkg::MODE_INIT;
            end
          end
        end
      end
      aai_pkg::OP_STATE: begin
        case (aai_pkg::state_cmd_t'(s1_r.mode_cmd))
          aai_pkg::SC_DISARM: begin
            if (mode_r == aai_pkg::MODE_ARMED) mode_nxt = aai_pkg::MODE_READY;
          end
          aai_pkg::SC_ARM: begin
            if (mode_r == aai_pkg::MODE_READY) mode_nxt = aai_pkg::MODE_ARMED;
          end
          aai_pkg::SC_CLEAR: begin
            if (mode_r == aai_pkg::MODE_ERROR) mode_nxt = aai_pkg::MODE_READY;
            emit     = 1'b1;
            code_raw = clear_code_r;
          end
          default: ;
        endcase
      end
      aai_pkg::OP_OPER: begin
        emit     = 1'b1;
        code_raw = s1_r.detwist_command;
        emit_pos = s1_r.command_position;
      end
      aai_pkg::OP_TARGET: begin
        fresh = age_r < timeout_r;
        if (fresh && s1_r.command_position[31:aai_pkg::WRAP_BITS] == '0) begin
          delta = aai_pkg::delta_t'({2'b00, s1_r.command_position[aai_pkg::WRAP_BITS-1:0]})
                - aai_pkg::delta_t'({2'b00, last_pos_r[aai_pkg::WRAP_BITS-1:0]});
          // fold into one period around the current position
          if (delta > aai_pkg::HALF_P) begin
            delta = delta - aai_pkg::PERIOD;
          end else if (delta < aai_pkg::HALF_N) begin
            delta = delta + aai_pkg::PERIOD;
          end
          sum = {{2{last_pos_r[31]}}, last_pos_r}
              + {{(aai_pkg::SUM_W - aai_pkg::DELTA_W){delta[aai_pkg::DELTA_W-1]}}, delta};
          // saturate to 32 bits signed
          if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            emit_pos = sum[31:0];
          end else if (sum[33]) begin
            emit_pos = 32'sh8000_0000;
          end else begin
            emit_pos = 32'sh7FFF_FFFF;
          end
          emit     = 1'b1;
          code_raw = (mode_r == aai_pkg::MODE_ARMED) ? move_code_r : 8'd0;
        end
      end
      default: ;
    endcase

    // Gate the code against the mode after this beat
    emit_code = code_raw;
    if (code_raw == move_code_r) begin
      if (mode_nxt != aai_pkg::MODE_ARMED) emit_code = 8'd0;
    end else if (code_raw == ref_code_r) begin
      if (mode_nxt != aai_pkg::MODE_READY) emit_code = 8'd0;
    end

    if (emit) begin
      res.send_command     = 1'b1;
      res.command_code     = emit_code;
      res.position         = emit_pos;
      res.command_sequence = seq_r;
      seq_nxt              = seq_r + 16'd1;
    end
    res.actuator_state = mode_nxt;
  end

  // State advances only when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= aai_pkg::MODE_INIT;
      age_r      <= aai_pkg::AGE_MAX;
      last_pos_r <= 32'sd0;
      seq_r      <= 16'd0;
    end else if (s1_valid_r && advance) begin
      mode_r     <= mode_nxt;
      age_r      <= age_nxt;
      last_pos_r <= last_pos_nxt;
      seq_r      <= seq_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_command     = out_r.send_command;
  assign out_command_code     = out_r.command_code;
  assign out_position         = out_r.position;
  assign out_command_sequence = out_r.command_sequence;
  assign out_actuator_state   = out_r.actuator_state;
  assign out_status_accepted  = out_r.status_accepted;

`ifndef SYNTHESIS
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && emit) |=> (seq_r == $past(seq_r) + 16'd1))
    else $error("sequence did not advance on an emitted command");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.send_command) |->
      (out_r.command_code == 8'd0 && out_r.position == 32'sd0 &&
       out_r.command_sequence == 16'd0))
    else $error("result without command carries nonzero command fields");

  a_accept_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status_accepted) |-> !out_r.send_command)
    else $error("status beat emitted a command");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while result register free");
`endif

endmodule

`default_nettype wire

[tb/actuator_arm_interlock_core_test.sv]
// Self-checking testbench for the actuator arm interlock core.
module actuator_arm_interlock_core_test;

  localparam int     CYCLE_LIMIT = 400000;
  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -64'sd2147483648;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic [2:0]         in_operation = '0;
  logic [15:0]        in_status_version = '0;
  logic [15:0]        in_status_error_flags = '0;
  logic [15:0]        in_status_info_flags = '0;
  logic signed [31:0] in_status_position = '0;
  logic [1:0]         in_mode_cmd = '0;
  logic [7:0]         in_detwist_command = '0;
  logic signed [31:0] in_command_position = '0;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire                out_send_command;
  wire  [7:0]         out_command_code;
  wire  signed [31:0] out_position;
  wire  [15:0]        out_command_sequence;
  wire  [1:0]         out_actuator_state;
  wire                out_status_accepted;

  actuator_arm_interlock_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_status_version    (in_status_version),
    .in_status_error_flags(in_status_error_flags),
    .in_status_info_flags (in_status_info_flags),
    .in_status_position   (in_status_position),
    .in_mode_cmd          (in_mode_cmd),
    .in_detwist_command   (in_detwist_command),
    .in_command_position  (in_command_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_command     (out_send_command),
    .out_command_code     (out_command_code),
    .out_position         (out_position),
    .out_command_sequence (out_command_sequence),
    .out_actuator_state   (out_actuator_state),
    .out_status_accepted  (out_status_accepted)
  );

  // Interlock shadow state and register copies.
  aai_pkg::mode_t     il_mode;
  logic [23:0]        il_age;
  logic signed [31:0] il_last_pos;
  logic [15:0]        il_seq;
  logic [23:0]        cf_timeout;
  logic               cf_bypass;
  logic [15:0]        cf_version;
  logic [15:0]        cf_servo_fault;
  logic [15:0]        cf_ready_mask;
  logic [7:0]         cf_move;
  logic [7:0]         cf_ref;
  logic [7:0]         cf_clear;

  aai_pkg::out_beat_t due_beats[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        tx_burst_left = 0;
  bit        tx_no_gaps = 1'b0;
  int        rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("actuator_arm_interlock_core_test: FAIL");
      $finish;
    end
  end

  // Receiver: free-flowing, light, heavy and long-hold stall windows in turn.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1'b1;
    end else begin
      case (cycle_count[10:9])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 1) == 0);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            rx_hold <= $urandom_range(1, 12);
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  task automatic report(input string field, input longint got, input longint want);
    if (mismatches < 100)
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch_results
    aai_pkg::out_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_beats.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        want = due_beats.pop_front();
        if (out_send_command !== want.send_command)
          report("send_command", out_send_command, want.send_command);
        if (out_command_code !== want.command_code)
          report("command_code", out_command_code, want.command_code);
        if (out_position !== want.position)
          report("position", out_position, want.position);
        if (out_command_sequence !== want.command_sequence)
          report("command_sequence", out_command_sequence, want.command_sequence);
        if (out_actuator_state !== want.actuator_state)
          report("actuator_state", out_actuator_state, want.actuator_state);
        if (out_status_accepted !== want.status_accepted)
          report("status_accepted", out_status_accepted, want.status_accepted);
      end
    end
  end

  function automatic void drop_if_stale();
    if (!(il_age < cf_timeout) &&
        (il_mode == aai_pkg::MODE_READY || il_mode == aai_pkg::MODE_ARMED))
      il_mode = aai_pkg::MODE_INIT;
  endfunction

  // Gate the code by mode, saturate the position, take a sequence number.
  function automatic void issue_command(input logic [7:0] code, input longint pos,
                                        inout aai_pkg::out_beat_t r);
    if (code == cf_move) begin
      if (il_mode != aai_pkg::MODE_ARMED) code = '0;
    end else if (code == cf_ref) begin
      if (il_mode != aai_pkg::MODE_READY) code = '0;
    end
    if (pos > POS_MAX) pos = POS_MAX;
    if (pos < POS_MIN) pos = POS_MIN;
    r.send_command = 1'b1;
    r.command_code = code;
    r.position = 32'(pos);
    r.command_sequence = il_seq;
    il_seq = il_seq + 16'd1;
  endfunction

  function automatic aai_pkg::out_beat_t interlock_step(input aai_pkg::in_beat_t b);
    aai_pkg::out_beat_t r;
    longint    period;
    longint    tgt;
    longint    cur;
    longint    delta;
    r = '0;
    period = longint'(1) << aai_pkg::WRAP_BITS;
    case (b.operation)
      aai_pkg::OP_TICK: begin
        if (il_age != aai_pkg::AGE_MAX) il_age = il_age + 24'd1;
        drop_if_stale();
      end
      aai_pkg::OP_STATUS: begin
        if (b.status_version == cf_version) begin
          r.status_accepted = 1'b1;
          il_last_pos = b.status_position;
          il_age = '0;
          if (!(il_age < cf_timeout)) begin
            drop_if_stale();
          end else begin
            if (b.status_error_flags != 0 &&
                !(cf_bypass && b.status_error_flags == cf_servo_fault))
              il_mode = aai_pkg::MODE_ERROR;
            if ((b.status_info_flags & cf_ready_mask) != 0 || cf_bypass) begin
              if (il_mode == aai_pkg::MODE_INIT) il_mode = aai_pkg::MODE_READY;
            end else if (il_mode == aai_pkg::MODE_READY ||
                         il_mode == aai_pkg::MODE_ARMED) begin
              il_mode = aai_pkg::MODE_INIT;
            end
          end
        end
      end
      aai_pkg::OP_STATE: begin
        case (b.mode_cmd)
          aai_pkg::SC_DISARM:
            if (il_mode == aai_pkg::MODE_ARMED) il_mode = aai_pkg::MODE_READY;
          aai_pkg::SC_ARM:
            if (il_mode == aai_pkg::MODE_READY) il_mode = aai_pkg::MODE_ARMED;
          aai_pkg::SC_CLEAR: begin
            if (il_mode == aai_pkg::MODE_ERROR) il_mode = aai_pkg::MODE_READY;
            issue_command(cf_clear, 0, r);
          end
          default: ;
        endcase
      end
      aai_pkg::OP_OPER:
        issue_command(b.detwist_command, longint'(b.command_position), r);
      aai_pkg::OP_TARGET: begin
        tgt = longint'(b.command_position);
        if (il_age < cf_timeout && tgt >= 0 && tgt < period) begin
          cur = longint'(il_last_pos) & (period - 1);
          delta = tgt - cur;
          if (delta > period / 2) delta -= period;
          else if (delta < -(period / 2)) delta += period;
          issue_command((il_mode == aai_pkg::MODE_ARMED) ? cf_move : 8'd0,
                        longint'(il_last_pos) + delta, r);
        end
      end
      default: ;
    endcase
    r.actuator_state = il_mode;
    return r;
  endfunction

  task automatic send_item(input aai_pkg::in_beat_t b);
    int gap;
    if (!tx_no_gaps && tx_burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_valid <= 1'b1;
    in_operation <= b.operation;
    in_status_version <= b.status_version;
    in_status_error_flags <= b.status_error_flags;
    in_status_info_flags <= b.status_info_flags;
    in_status_position <= b.status_position;
    in_mode_cmd <= b.mode_cmd;
    in_detwist_command <= b.detwist_command;
    in_command_position <= b.command_position;
    do @(posedge clk); while (in_stall !== 1'b0);
    due_beats.push_back(interlock_step(b));
  endtask

  // Drop valid and wait for every expected result to drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input aai_pkg::cfg_idx_t idx, input logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      aai_pkg::CFG_TIMEOUT:     cf_timeout = v;
      aai_pkg::CFG_ALLOW_NOPWR: cf_bypass = v[0];
      aai_pkg::CFG_VERSION:     cf_version = v[15:0];
      aai_pkg::CFG_SERVO_FAULT: cf_servo_fault = v[15:0];
      aai_pkg::CFG_READY_MASK:  cf_ready_mask = v[15:0];
      aai_pkg::CFG_MOVE_CODE:   cf_move = v[7:0];
      aai_pkg::CFG_REF_CODE:    cf_ref = v[7:0];
      aai_pkg::CFG_CLEAR_CODE:  cf_clear = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] timeout, input logic bypass,
                            input logic [15:0] version, input logic [15:0] servo,
                            input logic [15:0] mask, input logic [7:0] move_c,
                            input logic [7:0] ref_c, input logic [7:0] clear_c);
    settle();
    write_reg(aai_pkg::CFG_TIMEOUT, timeout);
    write_reg(aai_pkg::CFG_ALLOW_NOPWR, {23'd0, bypass});
    write_reg(aai_pkg::CFG_VERSION, {8'd0, version});
    write_reg(aai_pkg::CFG_SERVO_FAULT, {8'd0, servo});
    write_reg(aai_pkg::CFG_READY_MASK, {8'd0, mask});
    write_reg(aai_pkg::CFG_MOVE_CODE, {16'd0, move_c});
    write_reg(aai_pkg::CFG_REF_CODE, {16'd0, ref_c});
    write_reg(aai_pkg::CFG_CLEAR_CODE, {16'd0, clear_c});
  endtask

  function automatic aai_pkg::in_beat_t noise_beat(input aai_pkg::op_t op);
    aai_pkg::in_beat_t b;
    b.operation = op;
    b.status_version = 16'($urandom);
    b.status_error_flags = 16'($urandom);
    b.status_info_flags = 16'($urandom);
    b.status_position = $urandom;
    b.mode_cmd = 2'($urandom);
    b.detwist_command = 8'($urandom);
    b.command_position = $urandom;
    return b;
  endfunction

  task automatic send_tick();
    send_item(noise_beat(aai_pkg::OP_TICK));
  endtask

  task automatic send_status(input logic [15:0] ver, input logic [15:0] err,
                             input logic [15:0] info, input logic [31:0] pos);
    aai_pkg::in_beat_t b;
    b = noise_beat(aai_pkg::OP_STATUS);
    b.status_version = ver;
    b.status_error_flags = err;
    b.status_info_flags = info;
    b.status_position = pos;
    send_item(b);
  endtask

  task automatic send_state(input aai_pkg::state_cmd_t sc);
    aai_pkg::in_beat_t b;
    b = noise_beat(aai_pkg::OP_STATE);
    b.mode_cmd = sc;
    send_item(b);
  endtask

  task automatic send_oper(input logic [7:0] code, input logic [31:0] pos);
    aai_pkg::in_beat_t b;
    b = noise_beat(aai_pkg::OP_OPER);
    b.detwist_command = code;
    b.command_position = pos;
    send_item(b);
  endtask

  task automatic send_target(input logic [31:0] pos);
    aai_pkg::in_beat_t b;
    b = noise_beat(aai_pkg::OP_TARGET);
    b.command_position = pos;
    send_item(b);
  endtask

  // Positions close to the 32-bit limits, where unwrapping saturates, or random ones.
  function automatic logic [31:0] edge_position();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 70000);
      1: return 32'h8000_0000 + $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  function automatic aai_pkg::in_beat_t random_beat();
    aai_pkg::in_beat_t b;
    int          pick;
    int          sub;
    logic [31:0] period;
    period = 32'd1 << aai_pkg::WRAP_BITS;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    if (pick < 15) begin
      b = noise_beat(aai_pkg::OP_TICK);
    end else if (pick < 40) begin
      b = noise_beat(aai_pkg::OP_STATUS);
      if ($urandom_range(0, 99) < 85) b.status_version = cf_version;
      if (sub < 7) b.status_error_flags = '0;
      else if (sub < 9) b.status_error_flags = cf_servo_fault;
      if ($urandom_range(0, 3) != 0) b.status_info_flags = b.status_info_flags | cf_ready_mask;
      else b.status_info_flags = b.status_info_flags & ~cf_ready_mask;
      b.status_position = edge_position();
    end else if (pick < 60) begin
      b = noise_beat(aai_pkg::OP_STATE);
      if (sub < 5) b.mode_cmd = aai_pkg::SC_ARM;
      else if (sub < 7) b.mode_cmd = aai_pkg::SC_DISARM;
      else if (sub < 9) b.mode_cmd = aai_pkg::SC_CLEAR;
      else b.mode_cmd = aai_pkg::SC_NONE;
    end else if (pick < 75) begin
      b = noise_beat(aai_pkg::OP_OPER);
      if (sub < 3) b.detwist_command = cf_move;
      else if (sub < 6) b.detwist_command = cf_ref;
      else if (sub < 7) b.detwist_command = cf_clear;
      else if (sub < 8) b.detwist_command = '0;
      b.command_position = edge_position();
    end else begin
      b = noise_beat(aai_pkg::OP_TARGET);
      if (sub < 3) b.command_position = $urandom_range(0, period - 1);
      else if (sub < 4) b.command_position = 0;
      else if (sub < 5) b.command_position = period - 1;
      else if (sub < 7) b.command_position = period / 2 + $urandom_range(0, 2) - 1;
      else if (sub < 8) b.command_position = period;
      else if (sub < 9) b.command_position = -1;
    end
    return b;
  endfunction

  task automatic test_power_on_defaults();
    send_tick();                              // age stays saturated, stale
    send_oper(8'd1, 32'h7FFF_FFFF);           // move code gated while not armed
    send_target(32'd0);                       // stale: nothing emitted
    send_status(16'd5, 16'd0, 16'd1, 32'd77); // wrong version: ignored
    send_status(16'd0, 16'd0, 16'd0, 32'h7FFF_FFFF);
    send_status(16'd0, 16'd0, 16'hFFFF, 32'h7FFF_FFFF);
    send_oper(8'd2, 32'h8000_0000);           // reference passes when ready
    send_state(aai_pkg::SC_ARM);
    send_target(32'd0);                       // unwraps past max: saturate high
    send_oper(8'd1, 32'd12345);
    send_status(16'd0, 16'd0, 16'd1, 32'h8000_0000);
    send_target(32'h0000_FFFF);               // unwraps below min: saturate low
    send_target(32'hFFFF_FFFF);
    send_target(32'h0001_0000);
    send_state(aai_pkg::SC_NONE);
    send_state(aai_pkg::SC_DISARM);
    send_status(16'd0, 16'hFFFF, 16'd1, 32'd0);
    send_oper(8'd2, 32'd5);
    send_state(aai_pkg::SC_ARM);
    send_state(aai_pkg::SC_CLEAR);
    send_status(16'd0, 16'd0, 16'd0, 32'd0);  // ready flag gone: back to init
    send_target(32'h0000_8000);               // exactly half a period: no wrap
    send_target(32'h0000_8001);
  endtask

  task automatic test_bypass_and_servo_fault();
    set_config(24'd1000, 1'b1, 16'd0, 16'd4, 16'd1, 8'd1, 8'd2, 8'd112);
    send_status(16'd0, 16'd4, 16'd0, 32'd100);
    send_state(aai_pkg::SC_ARM);
    send_status(16'd0, 16'd5, 16'd0, 32'd100);
    send_state(aai_pkg::SC_CLEAR);
  endtask

  task automatic test_timeout_extremes();
    set_config(24'd1, 1'b0, 16'd0, 16'd1, 16'd1, 8'd1, 8'd2, 8'd112);
    send_status(16'd0, 16'd0, 16'd1, 32'd300);
    send_target(32'd200);
    send_tick();                              // one tick makes it stale
    send_target(32'd200);
    set_config(24'hFF_FFFF, 1'b0, 16'd0, 16'd1, 16'd1, 8'd1, 8'd2, 8'd112);
    send_status(16'd0, 16'd0, 16'd1, 32'd300);
    send_tick();
    send_target(32'd400);
  endtask

  task automatic test_register_extremes();
    set_config(24'hFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_status(16'hFFFF, 16'hFFFF, 16'd0, 32'd9);
    send_oper(8'hFF, 32'd1);
    send_state(aai_pkg::SC_CLEAR);
    set_config(24'd1, 1'b0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    send_status(16'd0, 16'd0, 16'hFFFF, 32'd9);
    send_oper(8'd0, 32'd1);
    send_state(aai_pkg::SC_CLEAR);
  endtask

  task automatic test_random_traffic();
    logic [23:0] timeout;
    logic [15:0] mask;
    logic [7:0]  move_c;
    logic [7:0]  ref_c;
    logic [7:0]  clear_c;
    int          sub;
    for (int phase = 0; phase < 8; phase++) begin
      sub = $urandom_range(0, 9);
      if (sub == 0) timeout = 24'd1;
      else if (sub == 1) timeout = 24'd1000;
      else if (sub == 2) timeout = 24'hFF_FFFF;
      else timeout = 24'($urandom_range(2, 40));
      sub = $urandom_range(0, 9);
      mask = (sub == 0) ? 16'd0 : (sub == 1) ? 16'hFFFF : 16'($urandom);
      move_c = 8'($urandom);
      ref_c = ($urandom_range(0, 4) == 0) ? move_c : 8'($urandom);
      clear_c = ($urandom_range(0, 4) == 0) ? move_c : 8'($urandom);
      set_config(timeout, 1'($urandom), 16'($urandom), 16'($urandom), mask,
                 move_c, ref_c, clear_c);
      tx_no_gaps = (phase % 3 == 0);
      repeat (180) send_item(random_beat());
    end
    tx_no_gaps = 1'b0;
  endtask

  initial begin
    il_mode = aai_pkg::MODE_INIT;
    il_age = aai_pkg::AGE_MAX;
    il_last_pos = '0;
    il_seq = '0;
    cf_timeout = 24'd1000;
    cf_bypass = 1'b0;
    cf_version = 16'd0;
    cf_servo_fault = 16'd1;
    cf_ready_mask = 16'd1;
    cf_move = 8'd1;
    cf_ref = 8'd2;
    cf_clear = 8'd112;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_power_on_defaults();
    test_bypass_and_servo_fault();
    test_timeout_extremes();
    test_register_extremes();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("actuator_arm_interlock_core_test: PASS");
    else
      $display("actuator_arm_interlock_core_test: FAIL");
    $finish;
  end

endmodule
